// ===== hw/rtl/fpmd_pkg.sv =====
// shared types and constants for the fixed-point multiply/divide unit
// no dependencies
`default_nettype none

package fpmd_pkg;

  typedef enum logic [2:0] {
    OP_MUL64      = 3'd0,
    OP_SPLIT      = 3'd1,
    OP_MULINT     = 3'd2,
    OP_DIV64      = 3'd3,
    OP_RDIV_SPLIT = 3'd4,
    OP_RDIV_WRAP  = 3'd5
  } fpmd_op_e;

  localparam logic [31:0] RECIP_NUM   = 32'd2147483647;
  localparam int unsigned RECIP_SHIFT = 5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpmd_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               divide_by_zero;
  } fpmd_out_t;

  // word context carried alongside the divider
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               dz;
    logic               neg;
  } fpmd_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpmd_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on fpmd_pkg
`default_nettype none

module fpmd_div_pipe #(
  parameter int unsigned NW = 50
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire fpmd_pkg::fpmd_ctl_t ctl_i,
  input  wire logic [NW-1:0]     num_i,
  input  wire logic [31:0]       den_i,
  output logic                   valid_o,
  output fpmd_pkg::fpmd_ctl_t    ctl_o,
  output logic [NW-1:0]          quo_o
);

  logic                st_v_q   [NW+1];
  fpmd_pkg::fpmd_ctl_t st_ctl_q [NW+1];
  logic [31:0]         st_rem_q [NW+1];
  logic [NW-1:0]       st_qn_q  [NW+1];
  logic [31:0]         st_den_q [NW+1];

  assign st_v_q[0]   = valid_i;
  assign st_ctl_q[0] = ctl_i;
  assign st_rem_q[0] = '0;
  assign st_qn_q[0]  = num_i;
  assign st_den_q[0] = den_i;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [32:0] sh_d;
    logic [32:0] diff_d;
    logic        ge_d;

    assign sh_d   = {st_rem_q[s], st_qn_q[s][NW-1]};
    assign ge_d   = sh_d >= {1'b0, st_den_q[s]};
    assign diff_d = sh_d - {1'b0, st_den_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[s+1] <= 1'b0;
      end else begin
        st_v_q[s+1] <= st_v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      st_ctl_q[s+1] <= st_ctl_q[s];
      st_den_q[s+1] <= st_den_q[s];
      st_rem_q[s+1] <= ge_d ? diff_d[31:0] : sh_d[31:0];
      st_qn_q[s+1]  <= {st_qn_q[s][NW-2:0], ge_d};
    end
  end

  assign valid_o = st_v_q[NW];
  assign ctl_o   = st_ctl_q[NW];
  assign quo_o   = st_qn_q[NW];

endmodule

`default_nettype wire

// ===== hw/rtl/fpmd_mul_unit.sv =====
// two-stage multiply and result select: products, then combine
// depends on fpmd_pkg
`default_nettype none

module fpmd_mul_unit #(
  parameter int unsigned FRAC_BITS = 18
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire fpmd_pkg::fpmd_ctl_t ctl_i,
  input  wire logic signed [31:0]  y_i,
  input  wire logic signed [31:0]  quot_i,
  output logic                     valid_o,
  output fpmd_pkg::fpmd_out_t      out_o
);

  localparam int unsigned IntBits = 32 - FRAC_BITS;

  logic signed [31:0] a_s, ia, iy, pa_t, py_t, pa, py;
  logic signed [63:0] p64_d;
  logic signed [31:0] pint_d, ss_d, c1_d, c2_d, lo_d;

  assign a_s  = ctl_i.a;
  assign ia   = a_s >>> FRAC_BITS;
  assign iy   = y_i >>> FRAC_BITS;
  assign pa_t = a_s << IntBits;
  assign py_t = y_i << IntBits;
  assign pa   = pa_t >>> IntBits;
  assign py   = py_t >>> IntBits;

  assign p64_d  = a_s * y_i;
  assign pint_d = a_s * iy;
  assign ss_d   = ia * iy;
  assign c1_d   = ia * py;
  assign c2_d   = iy * pa;
  assign lo_d   = (pa >>> 2) * (py >>> 2);

  logic                v1_q;
  fpmd_pkg::fpmd_ctl_t ctl1_q;
  logic signed [63:0]  p64_q;
  logic signed [31:0]  pint_q, ss_q, c1_q, c2_q, lo_q, quot1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl1_q  <= ctl_i;
    p64_q   <= p64_d;
    pint_q  <= pint_d;
    ss_q    <= ss_d;
    c1_q    <= c1_d;
    c2_q    <= c2_d;
    lo_q    <= lo_d;
    quot1_q <= quot_i;
  end

  logic signed [31:0] split_d, wrap_d, res_d;
  logic signed [31:0] p_lo;

  assign p_lo    = p64_q[31:0];
  assign split_d = (ss_q << FRAC_BITS) + c1_q + c2_q + (lo_q >>> IntBits);
  assign wrap_d  = p_lo >>> FRAC_BITS;

  always_comb begin
    case (ctl1_q.opcode)
      fpmd_pkg::OP_MUL64:      res_d = p64_q[FRAC_BITS+31:FRAC_BITS];
      fpmd_pkg::OP_SPLIT:      res_d = split_d;
      fpmd_pkg::OP_MULINT:     res_d = pint_q;
      fpmd_pkg::OP_DIV64:      res_d = quot1_q;
      fpmd_pkg::OP_RDIV_SPLIT: res_d = split_d;
      fpmd_pkg::OP_RDIV_WRAP:  res_d = wrap_d;
      default:                 res_d = '0;
    endcase
    if (ctl1_q.dz) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o.result         <= res_d;
    out_o.divide_by_zero <= ctl1_q.dz;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_point_q18_mul_div_unit.sv =====
// top level of the fixed-point multiply/divide unit
// depends on fpmd_pkg, fpmd_div_pipe, fpmd_mul_unit
//
// channel   | ports                     | direction | handshake
// ----------+---------------------------+-----------+------------------------------
// command   | start_i, busy_o, in_i     | in        | word taken when start_i & !busy_o
// result    | result_valid_o, out_o     | out       | one-cycle strobe, no back-pressure
//
// one word enters every cycle; it passes an entry register, then the divider,
// which resolves one quotient bit per stage over 32+FRAC_BITS stages, then a
// quotient fix-up stage and two multiply stages.
// busy_o stays low: the receiver cannot stall so nothing ever backs up.
// reset clears the valid bits only; data registers are left as they are.
`default_nettype none

module fixed_point_q18_mul_div_unit #(
  parameter int unsigned FRAC_BITS = 18
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire fpmd_pkg::fpmd_in_t in_i,
  output logic                    result_valid_o,
  output fpmd_pkg::fpmd_out_t     out_o
);

  // dividend width: |a| shifted up by the fraction bits
  localparam int unsigned NW = 32 + FRAC_BITS;

  assign busy_o = 1'b0;

  // entry decode: magnitudes and sign for the divider
  logic        is_div64, is_div;
  logic [31:0] mag_a, mag_b;

  assign is_div64 = in_i.opcode == fpmd_pkg::OP_DIV64;
  assign is_div   = in_i.opcode inside {fpmd_pkg::OP_DIV64, fpmd_pkg::OP_RDIV_SPLIT,
                                         fpmd_pkg::OP_RDIV_WRAP};
  assign mag_a    = in_i.operand_a[31] ? 32'(-in_i.operand_a) : in_i.operand_a;
  assign mag_b    = in_i.operand_b[31] ? 32'(-in_i.operand_b) : in_i.operand_b;

  logic                v0_q;
  fpmd_pkg::fpmd_ctl_t ctl0_q;
  logic [NW-1:0]       num0_q;
  logic [31:0]         den0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl0_q.opcode <= in_i.opcode;
    ctl0_q.a      <= in_i.operand_a;
    ctl0_q.b      <= in_i.operand_b;
    ctl0_q.dz     <= is_div && (in_i.operand_b == '0);
    // div64 sign follows both operands, reciprocal only the divisor
    ctl0_q.neg    <= is_div64 ? (in_i.operand_a[31] ^ in_i.operand_b[31])
                              : in_i.operand_b[31];
    num0_q        <= is_div64 ? {mag_a, {FRAC_BITS{1'b0}}} : NW'(fpmd_pkg::RECIP_NUM);
    den0_q        <= mag_b;
  end

  // quotient pipeline, every word rides through it to keep order
  logic                dv_valid;
  fpmd_pkg::fpmd_ctl_t dv_ctl;
  logic [NW-1:0]       dv_quo;

  fpmd_div_pipe #(
    .NW(NW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v0_q),
    .ctl_i  (ctl0_q),
    .num_i  (num0_q),
    .den_i  (den0_q),
    .valid_o(dv_valid),
    .ctl_o  (dv_ctl),
    .quo_o  (dv_quo)
  );

  // quotient fix-up: apply sign, wrap, build the second multiply operand
  logic [31:0] q_signed;
  logic        is_recip;

  assign q_signed = dv_ctl.neg ? 32'(-dv_quo[31:0]) : dv_quo[31:0];
  assign is_recip = dv_ctl.opcode inside {fpmd_pkg::OP_RDIV_SPLIT, fpmd_pkg::OP_RDIV_WRAP};

  logic                vq_q;
  fpmd_pkg::fpmd_ctl_t ctlq_q;
  logic signed [31:0]  y_q, quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
    end else begin
      vq_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ctlq_q <= dv_ctl;
    quot_q <= q_signed;
    y_q    <= is_recip ? (q_signed << fpmd_pkg::RECIP_SHIFT) : dv_ctl.b;
  end

  // products then final select
  fpmd_mul_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vq_q),
    .ctl_i  (ctlq_q),
    .y_i    (y_q),
    .quot_i (quot_q),
    .valid_o(result_valid_o),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
